// File: rtl/dks_pkg.sv
// ----------------------------------------------------------------------------
// dks_pkg
// Types, permutation tables and bit-select helpers for the DES key schedule.
// ----------------------------------------------------------------------------
package dks_pkg;

    localparam int KEY_W      = 64;
    localparam int HALF_W     = 28;
    localparam int SUBKEY_W   = 48;
    localparam int ROUND_W    = 4;
    localparam int ROUND_IDX_W = 5;
    localparam int NUM_ROUNDS = 16;

    localparam logic [ROUND_W-1:0] LAST_ROUND = ROUND_W'(NUM_ROUNDS - 1);

    // seed halves handed from front to back
    typedef struct packed {
        logic [HALF_W-1:0] c;
        logic [HALF_W-1:0] d;
    } t_seed;

    // queue status seen by its neighbors
    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_status;

    // key selection permutation, positions count from the key MSB
    localparam logic [6:0] PC1_TABLE [0:55] = '{
        7'd57, 7'd49, 7'd41, 7'd33, 7'd25, 7'd17, 7'd9,
        7'd1,  7'd58, 7'd50, 7'd42, 7'd34, 7'd26, 7'd18,
        7'd10, 7'd2,  7'd59, 7'd51, 7'd43, 7'd35, 7'd27,
        7'd19, 7'd11, 7'd3,  7'd60, 7'd52, 7'd44, 7'd36,
        7'd63, 7'd55, 7'd47, 7'd39, 7'd31, 7'd23, 7'd15,
        7'd7,  7'd62, 7'd54, 7'd46, 7'd38, 7'd30, 7'd22,
        7'd14, 7'd6,  7'd61, 7'd53, 7'd45, 7'd37, 7'd29,
        7'd21, 7'd13, 7'd5,  7'd28, 7'd20, 7'd12, 7'd4
    };

    // subkey compression permutation over C:D, positions count from the C MSB
    localparam logic [5:0] PC2_TABLE [0:47] = '{
        6'd14, 6'd17, 6'd11, 6'd24, 6'd1,  6'd5,
        6'd3,  6'd28, 6'd15, 6'd6,  6'd21, 6'd10,
        6'd23, 6'd19, 6'd12, 6'd4,  6'd26, 6'd8,
        6'd16, 6'd7,  6'd27, 6'd20, 6'd13, 6'd2,
        6'd41, 6'd52, 6'd31, 6'd37, 6'd47, 6'd55,
        6'd30, 6'd40, 6'd51, 6'd45, 6'd33, 6'd48,
        6'd44, 6'd49, 6'd39, 6'd56, 6'd34, 6'd53,
        6'd46, 6'd42, 6'd50, 6'd36, 6'd29, 6'd32
    };

    // 1 where the round rotates by two, 0 where by one
    localparam logic SHIFT_TWO [0:NUM_ROUNDS-1] = '{
        1'b0, 1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1,
        1'b0, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b1, 1'b0
    };

    function automatic t_seed pc1(input logic [KEY_W-1:0] key);
        logic [2*HALF_W-1:0] r;
        t_seed s;
        r = '0;
        for (int i = 0; i < 2*HALF_W; i++) begin
            r[2*HALF_W-1-i] = key[6'(KEY_W - int'(PC1_TABLE[i]))];
        end
        s.c = r[2*HALF_W-1:HALF_W];
        s.d = r[HALF_W-1:0];
        return s;
    endfunction

    function automatic logic [SUBKEY_W-1:0] pc2(input t_seed s);
        logic [2*HALF_W-1:0] cd;
        logic [SUBKEY_W-1:0] r;
        cd = {s.c, s.d};
        r = '0;
        for (int j = 0; j < SUBKEY_W; j++) begin
            r[SUBKEY_W-1-j] = cd[6'(2*HALF_W - int'(PC2_TABLE[j]))];
        end
        return r;
    endfunction

    function automatic logic [HALF_W-1:0] rotl28(input logic [HALF_W-1:0] v,
                                                input logic two);
        return two ? {v[HALF_W-3:0], v[HALF_W-1:HALF_W-2]}
                   : {v[HALF_W-2:0], v[HALF_W-1]};
    endfunction

endpackage

// File: rtl/dks_front.sv
// ----------------------------------------------------------------------------
// dks_front
// Takes key requests, applies the key selection permutation and holds the
// seed halves until the queue has room.
// ----------------------------------------------------------------------------
module dks_front (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_stall,
    input  logic [dks_pkg::KEY_W-1:0]   i_key_in,
    input  dks_pkg::t_q_status          i_q_status,
    output logic                        o_push,
    output dks_pkg::t_seed              o_seed
);

    logic           r_valid;
    logic           n_valid;
    dks_pkg::t_seed r_seed;
    logic           w_accept;

    assign o_push   = r_valid && !i_q_status.full;
    assign o_stall  = r_valid && i_q_status.full;
    assign w_accept = i_valid && !o_stall;
    assign o_seed   = r_seed;

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_seed <= dks_pkg::pc1(i_key_in);
        end
    end

endmodule

// File: rtl/dks_queue.sv
// ----------------------------------------------------------------------------
// dks_queue
// Short FIFO of seed halves between the front and the round sequencer.
// ----------------------------------------------------------------------------
module dks_queue #(
    parameter int DEPTH = 2
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  dks_pkg::t_seed     i_seed,
    input  logic               i_pop,
    output dks_pkg::t_seed     o_head,
    output dks_pkg::t_q_status o_status
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    dks_pkg::t_seed   r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic [PTR_W-1:0] n_wr_ptr;
    logic [PTR_W-1:0] n_rd_ptr;
    logic [CNT_W-1:0] n_count;
    logic             w_do_push;
    logic             w_do_pop;

    assign o_status.not_empty = (r_count != '0);
    assign o_status.full      = (r_count == CNT_W'(DEPTH));
    assign o_head             = r_mem[r_rd_ptr];

    assign w_do_push = i_push && !o_status.full;
    assign w_do_pop  = i_pop && o_status.not_empty;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_do_push) begin
            n_wr_ptr = (r_wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
        end
        if (w_do_pop) begin
            n_rd_ptr = (r_rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
        end
        if (w_do_push && !w_do_pop) begin
            n_count = r_count + 1'b1;
        end else if (w_do_pop && !w_do_push) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_seed;
        end
    end

endmodule

// File: rtl/dks_back.sv
// ----------------------------------------------------------------------------
// dks_back
// Round sequencer: rotates the halves once per cycle while not stalled,
// applies the subkey compression permutation and loads the result register.
// ----------------------------------------------------------------------------
module dks_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  dks_pkg::t_q_status                i_q_status,
    input  dks_pkg::t_seed                    i_head,
    output logic                              o_pop,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [dks_pkg::ROUND_IDX_W-1:0]   o_round_index,
    output logic [dks_pkg::SUBKEY_W-1:0]      o_subkey,
    output logic [dks_pkg::HALF_W-1:0]        o_c_half,
    output logic [dks_pkg::HALF_W-1:0]        o_d_half,
    output logic                              o_last_round
);

    logic                             r_busy;
    logic [dks_pkg::ROUND_W-1:0]      r_round;
    dks_pkg::t_seed                   r_halves;
    logic                             r_out_valid;
    logic [dks_pkg::ROUND_IDX_W-1:0]  r_round_index;
    logic [dks_pkg::SUBKEY_W-1:0]     r_subkey;
    logic [dks_pkg::HALF_W-1:0]       r_c_half;
    logic [dks_pkg::HALF_W-1:0]       r_d_half;
    logic                             r_last_round;

    logic                             n_busy;
    logic [dks_pkg::ROUND_W-1:0]      n_round;
    logic                             n_out_valid;

    logic                             w_advance;
    logic                             w_fire;
    logic [dks_pkg::ROUND_W-1:0]      w_round;
    dks_pkg::t_seed                   w_src;
    dks_pkg::t_seed                   w_rot;

    assign w_advance = !r_out_valid || !i_stall;
    assign w_fire    = w_advance && (r_busy || i_q_status.not_empty);
    // start a new key straight from the queue head when not mid-run
    assign o_pop     = w_advance && !r_busy && i_q_status.not_empty;

    assign w_round   = r_busy ? r_round : '0;
    assign w_src     = r_busy ? r_halves : i_head;
    assign w_rot.c   = dks_pkg::rotl28(w_src.c, dks_pkg::SHIFT_TWO[w_round]);
    assign w_rot.d   = dks_pkg::rotl28(w_src.d, dks_pkg::SHIFT_TWO[w_round]);

    always_comb begin
        n_busy      = r_busy;
        n_round     = r_round;
        n_out_valid = r_out_valid;
        if (w_advance) begin
            n_out_valid = w_fire;
        end
        if (w_fire) begin
            n_busy  = (w_round != dks_pkg::LAST_ROUND);
            n_round = w_round + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_round     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_busy      <= n_busy;
            r_round     <= n_round;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_fire) begin
            r_halves      <= w_rot;
            r_round_index <= {1'b0, w_round} + 1'b1;
            r_subkey      <= dks_pkg::pc2(w_rot);
            r_c_half      <= w_rot.c;
            r_d_half      <= w_rot.d;
            r_last_round  <= (w_round == dks_pkg::LAST_ROUND);
        end
    end

    assign o_valid       = r_out_valid;
    assign o_round_index = r_round_index;
    assign o_subkey      = r_subkey;
    assign o_c_half      = r_c_half;
    assign o_d_half      = r_d_half;
    assign o_last_round  = r_last_round;

endmodule

// File: rtl/des_key_schedule_core.sv
// ----------------------------------------------------------------------------
// des_key_schedule_core
// DES key schedule: one 64-bit key in, sixteen round subkeys out.
//
// Channel   Dir  Handshake            Payload
// key       in   i_valid / o_stall    i_key_in[63:0]
// subkey    out  o_valid / i_stall    o_round_index, o_subkey, o_c_half,
//                                     o_d_half, o_last_round
//
// One key yields 16 results, one per cycle from the round sequencer while
// the output is not stalled. Between key request and first subkey lie the
// front register, the queue and the result register.
// Reset is synchronous and clears only control state; nothing carries over
// between keys. A stall on the output freezes the sequencer; the front and
// queue keep taking keys until the queue fills.
// ----------------------------------------------------------------------------
module des_key_schedule_core #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_valid,
    output logic                              o_stall,
    input  logic [dks_pkg::KEY_W-1:0]         i_key_in,
    output logic                              o_valid,
    input  logic                              i_stall,
    output logic [dks_pkg::ROUND_IDX_W-1:0]   o_round_index,
    output logic [dks_pkg::SUBKEY_W-1:0]      o_subkey,
    output logic [dks_pkg::HALF_W-1:0]        o_c_half,
    output logic [dks_pkg::HALF_W-1:0]        o_d_half,
    output logic                              o_last_round
);

    dks_pkg::t_q_status w_q_status;
    dks_pkg::t_seed     w_push_seed;
    dks_pkg::t_seed     w_head;
    logic               w_push;
    logic               w_pop;

    dks_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_key_in   (i_key_in),
        .i_q_status (w_q_status),
        .o_push     (w_push),
        .o_seed     (w_push_seed)
    );

    dks_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_seed   (w_push_seed),
        .i_pop    (w_pop),
        .o_head   (w_head),
        .o_status (w_q_status)
    );

    dks_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_status    (w_q_status),
        .i_head        (w_head),
        .o_pop         (w_pop),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_round_index (o_round_index),
        .o_subkey      (o_subkey),
        .o_c_half      (o_c_half),
        .o_d_half      (o_d_half),
        .o_last_round  (o_last_round)
    );

endmodule
